// File: rtl/chunk_cache_lru_tags_top_assert.svh
// assertion macros for the chunk cache tag manager
// expects clk and rst to exist in the including module
`ifndef CHUNK_CACHE_LRU_TAGS_TOP_ASSERT_SVH
`define CHUNK_CACHE_LRU_TAGS_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define CCLT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cclt assertion failed");
`define CCLT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cclt assertion failed");
`else
`define CCLT_ASSERT_IMP(label, ante, cons)
`define CCLT_ASSERT_NXT(label, ante, cons)
`endif

`endif

// File: rtl/cclt_pkg.sv
// shared types and constants for the chunk cache tag manager
// no dependencies
`timescale 1ns / 1ps

package cclt_pkg;

  localparam int SLOTS      = 8;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int COORD_W    = 16;
  localparam int EDGE_SHIFT = 7;
  localparam int LAST_SHIFT = 2;
  localparam int TAG_ABC_W  = COORD_W - EDGE_SHIFT;
  localparam int TAG_D_W    = COORD_W - LAST_SHIFT;
  localparam int TAG_W      = 3 * TAG_ABC_W + TAG_D_W;
  localparam int OFFSET_W   = 3 * EDGE_SHIFT + LAST_SHIFT;

  localparam logic [1:0] CMD_READ   = 2'd0;
  localparam logic [1:0] CMD_WRITE  = 2'd1;
  localparam logic [1:0] CMD_WR_CUR = 2'd2;
  localparam logic [1:0] CMD_FLUSH  = 2'd3;

  typedef struct packed {
    logic load;
    logic access;
    logic flush;
  } cclt_cmd_t;

  typedef struct packed {
    logic is_flush;
    logic out_last;
  } cclt_status_t;

endpackage

// File: rtl/cclt_ctrl.sv
// control state machine for the chunk cache tag manager
// depends on cclt_pkg and chunk_cache_lru_tags_top_assert.svh
`timescale 1ns / 1ps
`include "chunk_cache_lru_tags_top_assert.svh"

module cclt_ctrl
  import cclt_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  cclt_status_t stat,
  output cclt_cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_EXEC  = 4'b0010,
    ST_FLUSH = 4'b0100,
    ST_WAIT  = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   flushing, flushing_next;

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_WAIT);

  always_comb begin
    state_next    = state;
    flushing_next = flushing;
    cmd           = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat.is_flush) begin
          cmd.flush     = 1'b1;
          flushing_next = 1'b1;
        end else begin
          cmd.access    = 1'b1;
          flushing_next = 1'b0;
        end
        state_next = ST_WAIT;
      end
      ST_FLUSH: begin
        cmd.flush  = 1'b1;
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (out_ready) begin
          state_next = (flushing && !stat.out_last) ? ST_FLUSH : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      flushing <= 1'b0;
    end else begin
      state    <= state_next;
      flushing <= flushing_next;
    end
  end

  `CCLT_ASSERT_IMP(a_one_side, out_valid, !in_ready)
  `CCLT_ASSERT_NXT(a_flush_more, out_valid && out_ready && !flushing,
                   state == ST_IDLE)
  `CCLT_ASSERT_IMP(a_single_op, 1'b1, !(cmd.access && cmd.flush))

endmodule

// File: rtl/cclt_datapath.sv
// tag, dirty, recency storage and result register for the chunk cache
// depends on cclt_pkg and chunk_cache_lru_tags_top_assert.svh
`timescale 1ns / 1ps
`include "chunk_cache_lru_tags_top_assert.svh"

module cclt_datapath
  import cclt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  cclt_cmd_t            cmd,
  output cclt_status_t         stat,
  input  logic [1:0]           command,
  input  logic [COORD_W-1:0]   coord_a,
  input  logic [COORD_W-1:0]   coord_b,
  input  logic [COORD_W-1:0]   coord_c,
  input  logic [COORD_W-1:0]   coord_d,
  output logic                 hit,
  output logic [SLOT_W-1:0]    slot,
  output logic [OFFSET_W-1:0]  offset,
  output logic                 fill_needed,
  output logic                 writeback,
  output logic [TAG_ABC_W-1:0] wb_chunk_a,
  output logic [TAG_ABC_W-1:0] wb_chunk_b,
  output logic [TAG_ABC_W-1:0] wb_chunk_c,
  output logic [TAG_D_W-1:0]   wb_chunk_d,
  output logic                 last
);

  logic [1:0]         in_cmd;
  logic [COORD_W-1:0] in_a, in_b, in_c, in_d;

  logic [TAG_W-1:0]  slot_tag [SLOTS];
  logic [SLOTS-1:0]  slot_valid;
  logic [SLOTS-1:0]  slot_dirty;
  logic [SLOT_W-1:0] slot_rank [SLOTS];
  logic [SLOT_W-1:0] cur_slot;
  logic              cur_valid;

  logic [TAG_W-1:0]    tag_in;
  logic [OFFSET_W-1:0] off_in;
  logic [SLOTS-1:0]    match;
  logic                cur_hit;
  logic                any_match;
  logic [SLOT_W-1:0]   hit_idx;
  logic                any_free;
  logic [SLOT_W-1:0]   free_idx;
  logic [SLOT_W-1:0]   lru_idx;
  logic [SLOT_W-1:0]   victim;
  logic [SLOT_W-1:0]   tgt;
  logic [SLOT_W-1:0]   rank_next [SLOTS];
  logic [SLOTS-1:0]    fmask;
  logic [SLOTS-1:0]    frest;
  logic                f_any;
  logic [SLOT_W-1:0]   f_idx;
  logic                do_fill;
  logic                evict_wb;

  assign tag_in = {in_a[COORD_W-1:EDGE_SHIFT], in_b[COORD_W-1:EDGE_SHIFT],
                   in_c[COORD_W-1:EDGE_SHIFT], in_d[COORD_W-1:LAST_SHIFT]};
  assign off_in = {in_a[EDGE_SHIFT-1:0], in_b[EDGE_SHIFT-1:0],
                   in_c[EDGE_SHIFT-1:0], in_d[LAST_SHIFT-1:0]};

  always_comb begin
    match     = '0;
    any_match = 1'b0;
    hit_idx   = '0;
    any_free  = 1'b0;
    free_idx  = '0;
    lru_idx   = '0;
    fmask     = slot_valid & slot_dirty;
    f_any     = |fmask;
    f_idx     = '0;
    for (int i = 0; i < SLOTS; i++) begin
      match[i] = slot_valid[i] && (slot_tag[i] == tag_in);
    end
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (match[i]) begin
        any_match = 1'b1;
        hit_idx   = SLOT_W'(i);
      end
      if (!slot_valid[i]) begin
        any_free = 1'b1;
        free_idx = SLOT_W'(i);
      end
      if (slot_rank[i] == '0) begin
        lru_idx = SLOT_W'(i);
      end
      if (fmask[i]) begin
        f_idx = SLOT_W'(i);
      end
    end
    cur_hit  = cur_valid && match[cur_slot];
    victim   = any_free ? free_idx : lru_idx;
    tgt      = any_match ? hit_idx : victim;
    do_fill  = !any_match;
    evict_wb = !any_free && slot_dirty[victim];
    frest        = fmask;
    frest[f_idx] = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (SLOT_W'(i) == tgt) begin
        rank_next[i] = SLOT_W'(SLOTS - 1);
      end else if (slot_rank[i] > slot_rank[tgt]) begin
        rank_next[i] = slot_rank[i] - 1'b1;
      end else begin
        rank_next[i] = slot_rank[i];
      end
    end
  end

  assign stat.is_flush = (in_cmd == CMD_FLUSH);
  assign stat.out_last = last;

  // input capture and tag store
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_cmd <= command;
      in_a   <= coord_a;
      in_b   <= coord_b;
      in_c   <= coord_c;
      in_d   <= coord_d;
    end
    if (cmd.access && in_cmd != CMD_WR_CUR && !cur_hit && do_fill) begin
      slot_tag[victim] <= tag_in;
    end
  end

  // slot state
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      slot_dirty <= '0;
      cur_slot   <= '0;
      cur_valid  <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_rank[i] <= SLOT_W'(i);
      end
    end else if (cmd.access) begin
      if (in_cmd == CMD_WR_CUR) begin
        if (cur_valid) begin
          slot_dirty[cur_slot] <= 1'b1;
        end
      end else if (cur_hit) begin
        if (in_cmd == CMD_WRITE) begin
          slot_dirty[cur_slot] <= 1'b1;
        end
      end else begin
        for (int i = 0; i < SLOTS; i++) begin
          slot_rank[i] <= rank_next[i];
        end
        cur_slot  <= tgt;
        cur_valid <= 1'b1;
        if (do_fill) begin
          slot_valid[victim] <= 1'b1;
          slot_dirty[victim] <= (in_cmd == CMD_WRITE);
        end else if (in_cmd == CMD_WRITE) begin
          slot_dirty[hit_idx] <= 1'b1;
        end
      end
    end else if (cmd.flush && f_any) begin
      slot_dirty[f_idx] <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.access) begin
      last        <= 1'b1;
      writeback   <= 1'b0;
      fill_needed <= 1'b0;
      wb_chunk_a  <= '0;
      wb_chunk_b  <= '0;
      wb_chunk_c  <= '0;
      wb_chunk_d  <= '0;
      if (in_cmd == CMD_WR_CUR) begin
        hit    <= cur_valid;
        slot   <= cur_valid ? cur_slot : '0;
        offset <= cur_valid ? off_in : '0;
      end else if (cur_hit) begin
        hit    <= 1'b1;
        slot   <= cur_slot;
        offset <= off_in;
      end else begin
        hit         <= any_match;
        slot        <= tgt;
        offset      <= off_in;
        fill_needed <= do_fill;
        if (do_fill && evict_wb) begin
          writeback  <= 1'b1;
          {wb_chunk_a, wb_chunk_b, wb_chunk_c, wb_chunk_d} <= slot_tag[victim];
        end
      end
    end else if (cmd.flush) begin
      hit         <= 1'b0;
      offset      <= '0;
      fill_needed <= 1'b0;
      slot        <= f_idx;
      writeback   <= f_any;
      last        <= ~|frest;
      if (f_any) begin
        {wb_chunk_a, wb_chunk_b, wb_chunk_c, wb_chunk_d} <= slot_tag[f_idx];
      end else begin
        {wb_chunk_a, wb_chunk_b, wb_chunk_c, wb_chunk_d} <= '0;
      end
    end
  end

  `CCLT_ASSERT_IMP(a_cur_resident, cur_valid, slot_valid[cur_slot])
  `CCLT_ASSERT_NXT(a_flush_clean, cmd.flush && f_any, !slot_dirty[$past(f_idx)])
  `CCLT_ASSERT_NXT(a_miss_mru,
                   cmd.access && in_cmd != CMD_WR_CUR && !cur_hit,
                   slot_rank[cur_slot] == SLOT_W'(SLOTS - 1))
  `CCLT_ASSERT_NXT(a_fill_nohit, cmd.access, !(fill_needed && hit))

endmodule

// File: rtl/chunk_cache_lru_tags_top.sv
// Tag, dirty and recency manager for an eight-slot fully associative chunk
// cache. Read and write items pass the accept state and an execute state in
// which all eight tags are compared and, unless the current slot hits, the
// recency ranks updated, then sit in the result register until taken. A
// flush gives one result per dirty slot in slot order, found by a priority
// pick over the dirty mask, or one clean result if none is dirty. The next
// item is accepted once the last result of the current one has been taken.
// depends on cclt_pkg, cclt_ctrl and cclt_datapath
`timescale 1ns / 1ps

module chunk_cache_lru_tags_top
  import cclt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           command,
  input  logic [COORD_W-1:0]   coord_a,
  input  logic [COORD_W-1:0]   coord_b,
  input  logic [COORD_W-1:0]   coord_c,
  input  logic [COORD_W-1:0]   coord_d,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 hit,
  output logic [SLOT_W-1:0]    slot,
  output logic [OFFSET_W-1:0]  offset,
  output logic                 fill_needed,
  output logic                 writeback,
  output logic [TAG_ABC_W-1:0] wb_chunk_a,
  output logic [TAG_ABC_W-1:0] wb_chunk_b,
  output logic [TAG_ABC_W-1:0] wb_chunk_c,
  output logic [TAG_D_W-1:0]   wb_chunk_d,
  output logic                 last
);

  cclt_cmd_t    cmd;
  cclt_status_t stat;

  cclt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cclt_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .command     (command),
    .coord_a     (coord_a),
    .coord_b     (coord_b),
    .coord_c     (coord_c),
    .coord_d     (coord_d),
    .hit         (hit),
    .slot        (slot),
    .offset      (offset),
    .fill_needed (fill_needed),
    .writeback   (writeback),
    .wb_chunk_a  (wb_chunk_a),
    .wb_chunk_b  (wb_chunk_b),
    .wb_chunk_c  (wb_chunk_c),
    .wb_chunk_d  (wb_chunk_d),
    .last        (last)
  );

endmodule

// File: dv/chunk_cache_lru_tags_top_test.sv
`timescale 1ns / 1ps
// testbench for chunk_cache_lru_tags_top: reads, writes, unchecked writes and flushes
// checked against a slot, dirty and recency predictor kept in the bench
// depends on cclt_pkg and chunk_cache_lru_tags_top
module chunk_cache_lru_tags_top_test;
  import cclt_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_GAP        = 18;
  localparam int RANDOM_ITEMS   = 100;
  localparam int TAG_POOL       = 12;
  localparam int SETTLE_CYCLES  = 20;

  typedef struct packed {
    logic [TAG_ABC_W-1:0] a;
    logic [TAG_ABC_W-1:0] b;
    logic [TAG_ABC_W-1:0] c;
    logic [TAG_D_W-1:0]   d;
  } chunk_tag_t;

  typedef struct packed {
    logic                hit;
    logic [SLOT_W-1:0]   slot;
    logic [OFFSET_W-1:0] offset;
    logic                fill_needed;
    logic                writeback;
    chunk_tag_t          wb_chunk;
    logic                last;
  } tag_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           command = CMD_READ;
  logic [COORD_W-1:0]   coord_a = '0;
  logic [COORD_W-1:0]   coord_b = '0;
  logic [COORD_W-1:0]   coord_c = '0;
  logic [COORD_W-1:0]   coord_d = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 hit;
  logic [SLOT_W-1:0]    slot;
  logic [OFFSET_W-1:0]  offset;
  logic                 fill_needed;
  logic                 writeback;
  logic [TAG_ABC_W-1:0] wb_chunk_a;
  logic [TAG_ABC_W-1:0] wb_chunk_b;
  logic [TAG_ABC_W-1:0] wb_chunk_c;
  logic [TAG_D_W-1:0]   wb_chunk_d;
  logic                 last;

  // predicted cache state
  logic              slot_full [SLOTS];
  chunk_tag_t        slot_chunk [SLOTS];
  logic              slot_dirty [SLOTS];
  logic [SLOT_W-1:0] slot_age [SLOTS];
  logic [SLOT_W-1:0] cur_slot;
  logic              cur_known;

  tag_result_t expected_results[$];
  int mismatches  = 0;
  int idle_cycles = 0;
  int rx_hold     = 0;
  bit tx_idle_on  = 1'b1;
  bit rx_idle_on  = 1'b1;

  chunk_cache_lru_tags_top i_dut (.*);

  always #1 clk = ~clk;

  function automatic void reset_model();
    for (int i = 0; i < SLOTS; i++) begin
      slot_full[i]  = 1'b0;
      slot_dirty[i] = 1'b0;
      slot_chunk[i] = '0;
      slot_age[i]   = SLOT_W'(i);
    end
    cur_slot  = '0;
    cur_known = 1'b0;
  endfunction

  function automatic void make_recent(int s);
    logic [SLOT_W-1:0] old_age;
    old_age = slot_age[s];
    for (int i = 0; i < SLOTS; i++)
      if (slot_age[i] > old_age) slot_age[i]--;
    slot_age[s] = SLOT_W'(SLOTS - 1);
  endfunction

  function automatic void predict_access(input logic [1:0] cmd,
                                         input logic [COORD_W-1:0] a, b, c, d);
    chunk_tag_t  t;
    tag_result_t r;
    int          victim;
    bit          any_dirty;
    t.a = a[COORD_W-1:EDGE_SHIFT];
    t.b = b[COORD_W-1:EDGE_SHIFT];
    t.c = c[COORD_W-1:EDGE_SHIFT];
    t.d = d[COORD_W-1:LAST_SHIFT];
    r = '0;
    r.last = 1'b1;
    r.offset = {a[EDGE_SHIFT-1:0], b[EDGE_SHIFT-1:0], c[EDGE_SHIFT-1:0], d[LAST_SHIFT-1:0]};
    if (cmd == CMD_FLUSH) begin
      any_dirty = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_full[i] && slot_dirty[i]) begin
          r = '0;
          r.slot = SLOT_W'(i);
          r.writeback = 1'b1;
          r.wb_chunk = slot_chunk[i];
          expected_results.push_back(r);
          slot_dirty[i] = 1'b0;
          any_dirty = 1'b1;
        end
      end
      if (any_dirty) begin
        r = expected_results.pop_back();
        r.last = 1'b1;
      end else begin
        r = '0;
        r.last = 1'b1;
      end
    end else if (cmd == CMD_WR_CUR) begin
      // ignored while no slot is current
      if (cur_known) begin
        slot_dirty[cur_slot] = 1'b1;
        r.hit = 1'b1;
        r.slot = cur_slot;
      end else begin
        r.offset = '0;
      end
    end else if (cur_known && slot_full[cur_slot] && slot_chunk[cur_slot] == t) begin
      // hit on the current slot leaves recency alone
      if (cmd == CMD_WRITE) slot_dirty[cur_slot] = 1'b1;
      r.hit = 1'b1;
      r.slot = cur_slot;
    end else begin
      victim = -1;
      for (int i = 0; i < SLOTS; i++)
        if (victim < 0 && slot_full[i] && slot_chunk[i] == t) victim = i;
      if (victim >= 0) begin
        make_recent(victim);
        if (cmd == CMD_WRITE) slot_dirty[victim] = 1'b1;
        r.hit = 1'b1;
      end else begin
        for (int i = 0; i < SLOTS; i++)
          if (victim < 0 && !slot_full[i]) victim = i;
        if (victim < 0) begin
          for (int i = 0; i < SLOTS; i++)
            if (victim < 0 && slot_age[i] == 0) victim = i;
          if (slot_dirty[victim]) begin
            r.writeback = 1'b1;
            r.wb_chunk = slot_chunk[victim];
          end
        end
        slot_chunk[victim] = t;
        slot_full[victim]  = 1'b1;
        slot_dirty[victim] = (cmd == CMD_WRITE);
        make_recent(victim);
        r.fill_needed = 1'b1;
      end
      cur_slot  = SLOT_W'(victim);
      cur_known = 1'b1;
      r.slot    = SLOT_W'(victim);
    end
    expected_results.push_back(r);
  endfunction

  function automatic chunk_tag_t random_chunk();
    chunk_tag_t t;
    t.a = TAG_ABC_W'($urandom);
    t.b = TAG_ABC_W'($urandom);
    t.c = TAG_ABC_W'($urandom);
    t.d = TAG_D_W'($urandom);
    return t;
  endfunction

  function automatic string result_text(tag_result_t r);
    return $sformatf("hit=%0d slot=%0d offset=%0d fill=%0d wb=%0d chunk=%0d/%0d/%0d/%0d last=%0d",
                     r.hit, r.slot, r.offset, r.fill_needed, r.writeback, r.wb_chunk.a,
                     r.wb_chunk.b, r.wb_chunk.c, r.wb_chunk.d, r.last);
  endfunction

  task automatic send_item(input logic [1:0] cmd, input logic [COORD_W-1:0] a, b, c, d);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    coord_a  <= a;
    coord_b  <= b;
    coord_c  <= c;
    coord_d  <= d;
    do @(posedge clk); while (!in_ready);
    predict_access(cmd, a, b, c, d);
  endtask

  task automatic access_chunk(input logic [1:0] cmd, input chunk_tag_t t);
    send_item(cmd, {t.a, EDGE_SHIFT'($urandom)}, {t.b, EDGE_SHIFT'($urandom)},
              {t.c, EDGE_SHIFT'($urandom)}, {t.d, LAST_SHIFT'($urandom)});
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic test_idle_start();
    send_item(CMD_WR_CUR, '1, '1, '1, '1);
    send_item(CMD_FLUSH, '0, '0, '0, '0);
    send_item(CMD_READ, '0, '0, '0, '0);
    send_item(CMD_WR_CUR, 16'h1234, 16'h00ff, 16'h0f0f, 16'h0003);
    send_item(CMD_FLUSH, '1, '1, '1, '1);
    wait_results_done();
  endtask

  task automatic test_coord_extremes();
    send_item(CMD_WRITE, '1, '1, '1, '1);
    send_item(CMD_READ, '1, '1, '1, '1);
    send_item(CMD_READ, 16'hff80, 16'hff80, 16'hff80, 16'hfffc);
    send_item(CMD_READ, 16'h007f, 16'h007f, 16'h007f, 16'h0003);
    send_item(CMD_FLUSH, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555);
    wait_results_done();
  endtask

  task automatic test_eviction();
    chunk_tag_t t;
    chunk_tag_t kept;
    kept = '0;
    for (int i = 0; i < 9; i++) begin
      t = '0;
      t.a = TAG_ABC_W'(i + 1);
      t.b = TAG_ABC_W'(3 * i);
      t.c = '1;
      t.d = TAG_D_W'(i * 1000);
      if (i == 5) kept = t;
      access_chunk((i % 3 == 2) ? CMD_READ : CMD_WRITE, t);
    end
    access_chunk(CMD_READ, kept);
    access_chunk(CMD_WRITE, random_chunk());
    send_item(CMD_FLUSH, '0, '0, '0, '0);
    send_item(CMD_FLUSH, '0, '0, '0, '0);
    wait_results_done();
  endtask

  task automatic test_result_stall();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    rx_hold = 100;
    for (int i = 0; i < 6; i++) access_chunk(CMD_WRITE, random_chunk());
    send_item(CMD_FLUSH, '1, '0, '1, '0);
    wait_results_done();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    chunk_tag_t pool [TAG_POOL];
    int         kind;
    logic [1:0] cmd;
    for (int i = 0; i < TAG_POOL; i++) pool[i] = random_chunk();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 20 == 0) begin
        tx_idle_on = ($urandom_range(0, 2) != 0);
        rx_idle_on = ($urandom_range(0, 2) != 0);
      end
      if ($urandom_range(0, 29) == 0) wait_results_done();
      if ($urandom_range(0, 15) == 0) pool[$urandom_range(0, TAG_POOL - 1)] = random_chunk();
      kind = $urandom_range(0, 99);
      cmd = (kind < 45) ? CMD_READ : (kind < 80) ? CMD_WRITE :
            (kind < 90) ? CMD_WR_CUR : CMD_FLUSH;
      if ($urandom_range(0, 9) == 0)
        send_item(cmd, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                  COORD_W'($urandom));
      else
        access_chunk(cmd, pool[$urandom_range(0, TAG_POOL - 1)]);
    end
    wait_results_done();
  endtask

  initial begin
    reset_model();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_idle_start();
    test_coord_extremes();
    test_eviction();
    test_result_stall();
    test_random_traffic();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : result_taker
    int stall;
    wait (rst == 1'b0);
    forever begin
      stall = rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      while (rx_hold > 0) begin
        out_ready <= 1'b0;
        rx_hold--;
        @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin : result_check
    tag_result_t want;
    tag_result_t got;
    if (!rst && out_valid && out_ready) begin
      got.hit         = hit;
      got.slot        = slot;
      got.offset      = offset;
      got.fill_needed = fill_needed;
      got.writeback   = writeback;
      got.wb_chunk.a  = wb_chunk_a;
      got.wb_chunk.b  = wb_chunk_b;
      got.wb_chunk.c  = wb_chunk_c;
      got.wb_chunk.d  = wb_chunk_d;
      got.last        = last;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transfer: actual %s", result_text(got));
      end else begin
        want = expected_results.pop_front();
        if (got.hit !== want.hit || got.slot !== want.slot || got.offset !== want.offset ||
            got.fill_needed !== want.fill_needed || got.writeback !== want.writeback ||
            got.wb_chunk.a !== want.wb_chunk.a || got.wb_chunk.b !== want.wb_chunk.b ||
            got.wb_chunk.c !== want.wb_chunk.c || got.wb_chunk.d !== want.wb_chunk.d ||
            got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %s actual %s", result_text(want),
                     result_text(got));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/cclt_pkg.sv
rtl/cclt_ctrl.sv
rtl/cclt_datapath.sv
rtl/chunk_cache_lru_tags_top.sv
dv/chunk_cache_lru_tags_top_test.sv
